// ===== hw/rtl/assert_macros.svh =====
// Assertion macros, included by the tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked implication check, disabled during reset.
`define BRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain clocked check with no reset qualifier.
`define BRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRT_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/brt_pkg.sv =====
// Shared types and constants of the bitmap run-length tracker.
package brt_pkg;
	localparam int CFG_W = 17;
	localparam int POS_W = 16;
	localparam int RUN_W = 17;
	localparam int REQ_W = 2;
	localparam int ST_W  = 2;

	localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RECOVER = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

	// write strobes toward the bitmap storage
	typedef struct packed {
		logic word_we;
		logic flag_we;
		logic flag_wdata;
	} brt_wr_t;
endpackage

// ===== hw/rtl/brt_bitmap.sv =====
// Cell bitmap words and per-block all-intact flags, registered reads.
module brt_bitmap import brt_pkg::*; #(
	parameter int WORD_BITS = 16,
	parameter int WORDS     = 4096,
	parameter int BLOCKS    = 256,
	parameter int WA_W      = 12,
	parameter int FA_W      = 8
) (
	input  logic                 clk,
	input  brt_wr_t              ctl,
	input  logic [WA_W-1:0]      word_addr,
	input  logic [WORD_BITS-1:0] word_wdata,
	input  logic [FA_W-1:0]      flag_addr,
	output logic [WORD_BITS-1:0] word_rd,
	output logic                 flag_rd
);
	logic [WORD_BITS-1:0] words_mem [WORDS];
	logic                 flags_mem [BLOCKS];

	always_ff @(posedge clk) begin
		if (ctl.word_we) begin
			words_mem[word_addr] <= word_wdata;
		end
		word_rd <= words_mem[word_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.flag_we) begin
			flags_mem[flag_addr] <= ctl.flag_wdata;
		end
		flag_rd <= flags_mem[flag_addr];
	end
endmodule

// ===== hw/rtl/bitmap_run_length_tracker.sv =====
// Top level of the bitmap run-length tracker.
//
// channel | dir | handshake              | word
// s_*     | in  | s_tvalid / s_tready    | tuser req_type, tdata position
// m_*     | out | m_tvalid / m_tready    | tdata run_length, tuser status
// cfg_*   | in  | cfg_valid / cfg_ready  | cell_count
//
// Work per word before the output load: destroy a bitmap read-modify-write;
// recover a pop, the mend and a rescan of the block words after it, at most
// BLOCK_SIZE/word width words; query one check on a broken cell, else scan
// steps of one cell or one whole intact block; range, empty, full, unused none.
// After reset and every cell_count write a clearing pass over all
// MAX_CELLS/min(BLOCK_SIZE,16) words refills the bitmap; no word is taken
// meanwhile. cell_count is taken only while idle and wins over an input word.
// One result sits in the output register, so the next word is accepted while
// m_tready is low; a second result waits in S_DONE. Sizes are powers of two.
`include "assert_macros.svh"
module bitmap_run_length_tracker import brt_pkg::*; #(
	parameter int MAX_CELLS     = 65536,
	parameter int BLOCK_SIZE    = 256,
	parameter int HISTORY_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [15:0] position
	input  logic [1:0]       s_tuser,   // [1:0] req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [16:0] run_length, rest zero
	output logic [1:0]       m_tuser,   // [1:0] status
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data   // cell_count
);
	localparam int CW         = $clog2(MAX_CELLS);
	localparam int LB         = $clog2(BLOCK_SIZE);
	localparam int WORD_BITS  = (BLOCK_SIZE < 16) ? BLOCK_SIZE : 16;
	localparam int LW         = $clog2(WORD_BITS);
	localparam int WORDS      = MAX_CELLS / WORD_BITS;
	localparam int WA_W       = (CW > LW) ? CW - LW : 1;
	localparam int NUM_BLOCKS = MAX_CELLS / BLOCK_SIZE;
	localparam int FA_W       = (CW > LB) ? CW - LB : 1;
	localparam int BWORDS     = BLOCK_SIZE / WORD_BITS;
	localparam int KW         = (BWORDS > 1) ? $clog2(BWORDS) : 1;
	localparam int HA_W       = $clog2(HISTORY_DEPTH);
	localparam int HC_W       = HA_W + 1;
	localparam int CC_MAX     = (MAX_CELLS > 131071) ? 131071 : MAX_CELLS;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_DISS  = 4'd2;
	localparam logic [3:0] S_DEV   = 4'd3;
	localparam logic [3:0] S_POP   = 4'd4;
	localparam logic [3:0] S_MGET  = 4'd5;
	localparam logic [3:0] S_MEV   = 4'd6;
	localparam logic [3:0] S_BISS  = 4'd7;
	localparam logic [3:0] S_BEV   = 4'd8;
	localparam logic [3:0] S_QEV   = 4'd9;
	localparam logic [3:0] S_LCHK  = 4'd10;
	localparam logic [3:0] S_LEV   = 4'd11;
	localparam logic [3:0] S_RCHK  = 4'd12;
	localparam logic [3:0] S_REV   = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	logic [3:0]       state_q;
	logic [CFG_W-1:0] cc_q;
	logic [HC_W-1:0]  cnt_q;
	logic [WA_W-1:0]  sweep_q;
	logic [POS_W-1:0] pos_q;       // request position, or popped position
	logic [RUN_W-1:0] lo_q, hi_q;  // run bounds, [lo, hi)
	logic [KW-1:0]    k_q;         // word within block during rescan
	logic [RUN_W-1:0] res_run_q;
	logic [ST_W-1:0]  res_st_q;
	logic             req_is_query_q;
	logic             mv_q;
	logic [RUN_W-1:0] mrun_q;
	logic [ST_W-1:0]  mst_q;

	logic [POS_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [POS_W-1:0] hist_rd_q;
	logic             hist_we;

	brt_wr_t              wr;
	logic [WA_W-1:0]      word_addr;
	logic [WORD_BITS-1:0] word_wdata;
	logic [FA_W-1:0]      flag_addr;
	logic [WORD_BITS-1:0] word_rd;
	logic                 flag_rd;

	logic [LW-1:0]    bit_sel;
	logic [RUN_W-1:0] lo_m1;
	logic             in_acc;
	logic             pos_bad;
	logic             out_load;
	logic [CFG_W-1:0] cfg_v;

	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign pos_bad   = ({1'b0, s_tdata} >= cc_q);
	assign lo_m1     = lo_q - 1'b1;
	assign hist_we   = in_acc && (s_tuser == REQ_DESTROY) && !pos_bad &&
		(cnt_q != HC_W'(HISTORY_DEPTH));
	assign out_load  = (state_q == S_DONE) && (!mv_q || m_tready);

	// cell_count clamp: 0 means one cell, anything past the array is capped
	always_comb begin
		cfg_v = cfg_data;
		if (cfg_data == '0) begin
			cfg_v = CFG_W'(1);
		end else if (32'(cfg_data) > CC_MAX) begin
			cfg_v = CFG_W'(CC_MAX);
		end
	end

	// history store: push at cnt before increment, pop at cnt after decrement
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[cnt_q[HA_W-1:0]] <= s_tdata;
		end
		hist_rd_q <= hist_mem[cnt_q[HA_W-1:0]];
	end

	// bitmap address and write selection per sequencer step
	always_comb begin
		wr         = '0;
		word_addr  = WA_W'(pos_q >> LW);
		word_wdata = word_rd;
		flag_addr  = FA_W'(pos_q >> LB);
		bit_sel    = pos_q[LW-1:0];
		unique case (state_q) inside
			S_CLEAR: begin
				word_addr      = sweep_q;
				flag_addr      = FA_W'(sweep_q);
				word_wdata     = '1;
				wr.word_we     = 1'b1;
				wr.flag_we     = (32'(sweep_q) < NUM_BLOCKS);
				wr.flag_wdata  = 1'b1;
			end
			S_DEV: begin
				word_wdata         = word_rd;
				word_wdata[bit_sel] = 1'b0;
				wr.word_we         = 1'b1;
				wr.flag_we         = 1'b1;
				wr.flag_wdata      = 1'b0;
			end
			S_MGET: begin
				word_addr = WA_W'(hist_rd_q >> LW);
			end
			S_MEV: begin
				word_wdata          = word_rd;
				word_wdata[bit_sel] = 1'b1;
				wr.word_we          = 1'b1;
			end
			S_BISS: begin
				word_addr = WA_W'((32'(pos_q >> LB) << (LB - LW)) | 32'(k_q));
			end
			S_BEV: begin
				wr.flag_we    = (word_rd == '1) && (32'(k_q) == BWORDS - 1);
				wr.flag_wdata = 1'b1;
			end
			S_LCHK, S_LEV: begin
				word_addr = WA_W'(lo_m1 >> LW);
				flag_addr = FA_W'((lo_q >> LB) - 1'b1);
				bit_sel   = lo_m1[LW-1:0];
			end
			S_RCHK, S_REV: begin
				word_addr = WA_W'(hi_q >> LW);
				flag_addr = FA_W'(hi_q >> LB);
				bit_sel   = hi_q[LW-1:0];
			end
			default: begin
			end
		endcase
	end

	brt_bitmap #(
		.WORD_BITS (WORD_BITS),
		.WORDS     (WORDS),
		.BLOCKS    (NUM_BLOCKS),
		.WA_W      (WA_W),
		.FA_W      (FA_W)
	) u_bitmap (
		.clk        (clk),
		.ctl        (wr),
		.word_addr  (word_addr),
		.word_wdata (word_wdata),
		.flag_addr  (flag_addr),
		.word_rd    (word_rd),
		.flag_rd    (flag_rd)
	);

	// sequencer; a cell_count write restarts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cc_q      <= CFG_W'(CC_MAX);
			cnt_q     <= '0;
			sweep_q   <= '0;
			pos_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			k_q       <= '0;
			res_run_q <= '0;
			res_st_q  <= ST_OK;
		end else if (cfg_valid && cfg_ready) begin
			cc_q    <= cfg_v;
			cnt_q   <= '0;
			sweep_q <= '0;
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pos_q     <= s_tdata;
						res_run_q <= '0;
						res_st_q  <= ST_OK;
						state_q   <= S_DONE;
						case (s_tuser)
							REQ_DESTROY: begin
								if (pos_bad) begin
									res_st_q <= ST_RANGE;
								end else if (cnt_q == HC_W'(HISTORY_DEPTH)) begin
									res_st_q <= ST_FULL;
								end else begin
									cnt_q   <= cnt_q + 1'b1;
									state_q <= S_DISS;
								end
							end
							REQ_RECOVER: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_EMPTY;
								end else begin
									cnt_q   <= cnt_q - 1'b1;
									state_q <= S_POP;
								end
							end
							REQ_QUERY: begin
								if (pos_bad) begin
									res_st_q <= ST_RANGE;
								end else begin
									state_q <= S_DISS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (32'(sweep_q) == WORDS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_DISS: begin
					// word read shared by destroy and the query's first check
					state_q <= req_is_query_q ? S_QEV : S_DEV;
				end
				S_DEV: begin
					state_q <= S_DONE;
				end
				S_POP: begin
					state_q <= S_MGET;
				end
				S_MGET: begin
					pos_q   <= hist_rd_q;
					state_q <= S_MEV;
				end
				S_MEV: begin
					k_q     <= '0;
					state_q <= S_BISS;
				end
				S_BISS: begin
					state_q <= S_BEV;
				end
				S_BEV: begin
					if (word_rd != '1 || 32'(k_q) == BWORDS - 1) begin
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_BISS;
					end
				end
				S_QEV: begin
					if (!word_rd[bit_sel]) begin
						state_q <= S_DONE;
					end else begin
						lo_q    <= RUN_W'(pos_q);
						hi_q    <= RUN_W'(pos_q) + 1'b1;
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					state_q <= (lo_q == '0) ? S_RCHK : S_LEV;
				end
				S_LEV: begin
					if (lo_q[LB-1:0] == '0 && flag_rd) begin
						lo_q    <= lo_q - RUN_W'(BLOCK_SIZE);
						state_q <= S_LCHK;
					end else if (word_rd[bit_sel]) begin
						lo_q    <= lo_m1;
						state_q <= S_LCHK;
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					if (hi_q >= cc_q) begin
						res_run_q <= hi_q - lo_q;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_REV;
					end
				end
				S_REV: begin
					if (hi_q[LB-1:0] == '0 && flag_rd &&
						({1'b0, hi_q} + 18'(BLOCK_SIZE) <= {1'b0, cc_q})) begin
						hi_q    <= hi_q + RUN_W'(BLOCK_SIZE);
						state_q <= S_RCHK;
					end else if (word_rd[bit_sel]) begin
						hi_q    <= hi_q + 1'b1;
						state_q <= S_RCHK;
					end else begin
						res_run_q <= hi_q - lo_q;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_is_query_q <= 1'b0;
		end else if (in_acc) begin
			req_is_query_q <= (s_tuser == REQ_QUERY);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q   <= 1'b0;
			mrun_q <= '0;
			mst_q  <= ST_OK;
		end else if (out_load) begin
			mv_q   <= 1'b1;
			mrun_q <= res_run_q;
			mst_q  <= res_st_q;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {7'd0, mrun_q};
	assign m_tuser  = mst_q;

	`BRT_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= HC_W'(HISTORY_DEPTH),
		"history count past depth")
	`BRT_ASSERT(a_run_ok, clk, arst_n, (m_tvalid && m_tdata != '0) |-> (m_tuser == ST_OK),
		"run with error status")
	`BRT_ASSERT(a_range_hold, clk, arst_n,
		(in_acc && s_tuser == REQ_DESTROY && pos_bad && !cfg_valid) |=> $stable(cnt_q),
		"range error moved store")
	`BRT_ASSERT(a_cfg_clear, clk, arst_n,
		(cfg_valid && cfg_ready) |=> (state_q == S_CLEAR && cnt_q == '0),
		"config did not start clear")
endmodule

// ===== test/tb_bitmap_run_length_tracker.sv =====
// Testbench for the bitmap run-length tracker, checked against a predictor.
`timescale 1ns / 1ps
module tb_bitmap_run_length_tracker import brt_pkg::*; ();

	localparam int NCELL_MAX  = 65536;
	localparam int GROUP      = 256;
	localparam int STACK_MAX  = 4096;
	localparam int STALL_LIMIT = 30000;

	typedef struct {
		logic [REQ_W-1:0] kind;
		logic [POS_W-1:0] pos;
	} request_t;

	typedef struct {
		logic [RUN_W-1:0] run;
		logic [ST_W-1:0]  st;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [23:0]      m_tdata;
	logic [1:0]       m_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	bitmap_run_length_tracker u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's state
	bit          cell_ok [NCELL_MAX];
	bit          group_ok [NCELL_MAX/GROUP];
	logic [15:0] broken_stack [STACK_MAX];
	int          stack_top;
	int          ncells;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];

	// phase knobs, written by the initial block only
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int hold_epoch = 0;
	// receiver-owned hold-off state
	int seen_epoch = 0;
	int hold_cnt = 0;

	int errors = 0;
	int n_words = 0;
	int n_queries = 0;
	int n_full = 0;
	int n_range = 0;
	int n_empty = 0;
	int idle_cycles = 0;

	function automatic void restore_cells(logic [CFG_W-1:0] v);
		int n;
		n = int'(v);
		if (n == 0)
			n = 1;
		if (n > NCELL_MAX)
			n = NCELL_MAX;
		ncells = n;
		foreach (cell_ok[i]) cell_ok[i] = 1'b1;
		foreach (group_ok[i]) group_ok[i] = 1'b1;
		stack_top = 0;
	endfunction

	function automatic void mend(int p);
		int base;
		base = (p / GROUP) * GROUP;
		cell_ok[p] = 1'b1;
		for (int i = 0; i < GROUP; i++)
			if (!cell_ok[base + i])
				return;
		group_ok[p / GROUP] = 1'b1;
	endfunction

	// walk out both ways, hopping whole intact groups where aligned
	function automatic int intact_run(int p);
		int lo, hi;
		lo = p;
		hi = p + 1;
		if (!cell_ok[p])
			return 0;
		while (lo > 0) begin
			if (lo % GROUP == 0 && group_ok[lo/GROUP - 1])
				lo -= GROUP;
			else if (cell_ok[lo-1])
				lo--;
			else
				break;
		end
		while (hi < ncells) begin
			if (hi % GROUP == 0 && hi + GROUP <= ncells && group_ok[hi/GROUP])
				hi += GROUP;
			else if (cell_ok[hi])
				hi++;
			else
				break;
		end
		return hi - lo;
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		int p;
		a.run = '0;
		a.st = ST_OK;
		p = int'(r.pos);
		case (r.kind)
			REQ_DESTROY: begin
				if (p >= ncells)
					a.st = ST_RANGE;
				else if (stack_top >= STACK_MAX)
					a.st = ST_FULL;
				else begin
					broken_stack[stack_top] = r.pos;
					stack_top++;
					cell_ok[p] = 1'b0;
					group_ok[p / GROUP] = 1'b0;
				end
			end
			REQ_RECOVER: begin
				if (stack_top == 0)
					a.st = ST_EMPTY;
				else begin
					stack_top--;
					mend(int'(broken_stack[stack_top]));
				end
			end
			REQ_QUERY: begin
				if (p >= ncells)
					a.st = ST_RANGE;
				else
					a.run = RUN_W'(intact_run(p));
			end
			default: ;   // unused code: ignored
		endcase
		return a;
	endfunction

	// sender: one update per edge, new word only once the old one is gone
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			request_t r;
			r.kind = s_tuser;
			r.pos = s_tdata;
			expected_answers.push_back(predict_answer(r));
			n_words++;
		end
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				request_t r;
				r = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.kind;
				s_tdata <= r.pos;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver with random stalls; a new hold epoch starts a long hold-off
	always @(posedge clk) begin
		if (hold_epoch != seen_epoch) begin
			seen_epoch <= hold_epoch;
			hold_cnt <= hold_len;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// checker
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected word run=%0d status=%0d", $time,
					m_tdata, m_tuser);
				errors++;
			end else begin
				answer_t a;
				a = expected_answers.pop_front();
				if (m_tdata !== {7'd0, a.run}) begin
					$display("%0t: run_length expected %0d actual %0d", $time, a.run, m_tdata);
					errors++;
				end
				if (m_tuser !== a.st) begin
					$display("%0t: status expected %0d actual %0d", $time, a.st, m_tuser);
					errors++;
				end
				if (a.st == ST_FULL) n_full++;
				if (a.st == ST_RANGE) n_range++;
				if (a.st == ST_EMPTY) n_empty++;
				if (a.st == ST_OK && a.run != 0) n_queries++;
			end
		end
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic queue_req(logic [REQ_W-1:0] k, int p);
		request_t r;
		r.kind = k;
		r.pos = p[POS_W-1:0];
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cells(logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		restore_cells(v);
	endtask

	// mostly clustered traffic so destroys, recovers and queries interact
	task automatic queue_random(int count);
		int base, p, pick;
		base = $urandom_range(ncells - 1);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(31) == 0)
				base = $urandom_range(ncells - 1);
			if ($urandom_range(9) == 0)
				p = $urandom_range(16'hFFFF);
			else
				p = (base + $urandom_range(40)) % (ncells + 2);
			pick = $urandom_range(99);
			if (pick < 40)
				queue_req(REQ_DESTROY, p);
			else if (pick < 63)
				queue_req(REQ_RECOVER, $urandom_range(16'hFFFF));
			else if (pick < 95)
				queue_req(REQ_QUERY, p);
			else
				queue_req(REQ_UNUSED, $urandom_range(16'hFFFF));
		end
	endtask

	initial begin
		restore_cells(CFG_W'(NCELL_MAX));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edges of the bitmap, group boundaries, empty store, repeat destroy
		queue_req(REQ_QUERY, 0);
		queue_req(REQ_QUERY, 16'hFFFF);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_DESTROY, 0);
		queue_req(REQ_DESTROY, 16'hFFFF);
		queue_req(REQ_DESTROY, 16'hFFFF);
		queue_req(REQ_QUERY, 1);
		queue_req(REQ_QUERY, 16'hFFFE);
		queue_req(REQ_DESTROY, 256);
		queue_req(REQ_QUERY, 255);
		queue_req(REQ_QUERY, 256);
		queue_req(REQ_QUERY, 257);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_QUERY, 300);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_QUERY, 16'hFFFF);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_QUERY, 16'hFFFF);
		queue_req(REQ_UNUSED, 16'hFFFF);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_RECOVER, 0);
		queue_req(REQ_QUERY, 12345);
		wait_drained();

		// single cell (zero written, taken as one)
		write_cells(17'd0);
		queue_random(80);
		wait_drained();

		// oversize value, clipped to the full bitmap; sender idles, long output hold-off
		write_cells(17'h1FFFF);
		idle_pct = 45;
		hold_len = 400;
		hold_epoch++;
		queue_random(300);
		wait_drained();

		write_cells(17'd300);
		idle_pct = 0;
		stall_pct = 45;
		queue_random(250);
		wait_drained();

		write_cells(17'd600);
		idle_pct = 29;
		stall_pct = 29;
		queue_random(250);
		wait_drained();

		// deep store on a tiny bitmap: repeated destroys, then unwinding
		write_cells(17'd16);
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 150; i++)
			queue_req(REQ_DESTROY, $urandom_range(15));
		queue_req(REQ_QUERY, 3);
		for (int i = 0; i < 60; i++)
			queue_req(REQ_RECOVER, 0);
		queue_random(40);
		wait_drained();

		$display("Covered %0d words over six cell counts (1 to %0d cells).", n_words, NCELL_MAX);
		$display("Nonzero runs %0d, range errors %0d, empty %0d, full %0d, mismatches %0d.",
			n_queries, n_range, n_empty, n_full, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
